// ===== rtl/tcp_retransmit_timeout_estimator_core_macros.svh =====
// Assertion shorthands shared by the verification code of the timeout estimator.
`ifndef TCP_RETRANSMIT_TIMEOUT_ESTIMATOR_CORE_MACROS_SVH
`define TCP_RETRANSMIT_TIMEOUT_ESTIMATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCP_RTO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCP_RTO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tcp_rto_pkg.sv =====
package tcp_rto_pkg;

	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 16;
	localparam int MS_W      = 16;
	localparam int TIMEOUT_W = 26;
	localparam int FUNC_W    = 2;
	localparam int CFG_IDX_W = 2;

	typedef logic [FUNC_W-1:0]    func_t;
	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [MS_W-1:0]      ms_t;
	typedef logic [TIMEOUT_W-1:0] timeout_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Event kinds.
	localparam func_t FUNC_WRITE = 2'd0;
	localparam func_t FUNC_ACK   = 2'd1;
	localparam func_t FUNC_CHECK = 2'd2;

	// Configuration register indexes.
	localparam cfg_idx_t REG_INITIAL_TIMEOUT = 2'd0;
	localparam cfg_idx_t REG_BACKOFF_STEP    = 2'd1;
	localparam cfg_idx_t REG_MAX_TIMEOUT     = 2'd2;

	localparam ms_t INITIAL_TIMEOUT_RST = 16'd1000;
	localparam ms_t BACKOFF_STEP_RST    = 16'd1000;
	localparam ms_t MAX_TIMEOUT_RST     = 16'd10000;

	localparam logic [9:0] US_PER_MS      = 10'd1000;
	localparam timeout_t   MIN_TIMEOUT_US = 26'd3000;

	// Operations of the shared arithmetic unit.
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD      = 2'd0;
	localparam alu_op_t ALU_SUB      = 2'd1;
	localparam alu_op_t ALU_MS_TO_US = 2'd2;

endpackage

// ===== rtl/tcp_rto_req_if.sv =====
interface tcp_rto_req_if import tcp_rto_pkg::*; ();
	logic   valid;
	logic   ready;
	func_t  func;
	time_t  now_us;
	count_t byte_count;
	logic   nothing_unacked;

	modport source (output valid, func, now_us, byte_count, nothing_unacked, input ready);
	modport sink (input valid, func, now_us, byte_count, nothing_unacked, output ready);
endinterface

interface tcp_rto_rsp_if import tcp_rto_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     retransmit;
	timeout_t timeout_us;
	time_t    deadline_us;
	logic     timing_open;

	modport source (output valid, retransmit, timeout_us, deadline_us, timing_open, input ready);
	modport sink (input valid, retransmit, timeout_us, deadline_us, timing_open, output ready);
endinterface

interface tcp_rto_cfg_if import tcp_rto_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	ms_t      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tcp_rto_alu.sv =====
module tcp_rto_alu import tcp_rto_pkg::*; #(
	parameter int WIDTH = 34
) (
	input  alu_op_t          op,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic [WIDTH-1:0] res,
	output logic             carry
);

	logic [WIDTH:0]     wide;
	logic [TIMEOUT_W-1:0] prod;

	// Millisecond to microsecond conversion of a 16-bit register value.
	assign prod = TIMEOUT_W'(a[MS_W-1:0]) * TIMEOUT_W'(US_PER_MS);

	always_comb begin
		case (op)
			ALU_ADD:      wide = {1'b0, a} + {1'b0, b};
			ALU_SUB:      wide = {1'b0, a} - {1'b0, b};
			ALU_MS_TO_US: wide = (WIDTH+1)'(prod);
			default:      wide = '0;
		endcase
	end

	// For a subtraction the top bit is the borrow, that is a < b.
	assign res   = wide[WIDTH-1:0];
	assign carry = wide[WIDTH];

endmodule

// ===== rtl/tcp_rto_div.sv =====
module tcp_rto_div #(
	parameter int WIDTH   = 34,
	parameter int DIVISOR = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);

	localparam int DIG_W   = 16;
	localparam int CYCLES  = (WIDTH + DIG_W - 1) / DIG_W;
	localparam int PAD_W   = CYCLES * DIG_W;
	localparam int RW      = $clog2(DIVISOR + 1);
	localparam int X_W     = RW + DIG_W;
	// The reciprocal is rounded up by less than one divisor, which stays below
	// one quotient step for every partial dividend as long as the divisor is
	// at most 16.
	localparam int SHIFT   = X_W + 4;
	localparam int RECIP_W = SHIFT + 1;
	localparam int PROD_W  = X_W + RECIP_W;
	localparam int CNT_W   = $clog2(CYCLES + 1);
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
	localparam logic [X_W-1:0] DIV_VAL = X_W'(DIVISOR);

	logic [PAD_W-1:0]  work_q;
	logic [RW-1:0]     rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [X_W-1:0]    part_w;
	logic [PROD_W-1:0] prod_w;
	logic [DIG_W-1:0]  qdig_w;
	logic [X_W-1:0]    back_w;
	logic [PAD_W-1:0]  work_d;
	logic [RW-1:0]     rem_d;

	// Long division in 16-bit digits, most significant first. Each digit,
	// with the remainder of the digit above, is divided by multiplying with
	// the reciprocal. Dividend digits leave the top of the work register while
	// quotient digits enter at the bottom.
	assign part_w = {rem_q, work_q[PAD_W-1 -: DIG_W]};
	assign prod_w = PROD_W'(part_w) * PROD_W'(RECIP);
	assign qdig_w = prod_w[SHIFT +: DIG_W];
	assign back_w = X_W'(qdig_w) * DIV_VAL;
	assign rem_d  = RW'(part_w - back_w);
	assign work_d = {work_q[PAD_W-DIG_W-1:0], qdig_w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(CYCLES);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= PAD_W'(dividend);
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = work_q[WIDTH-1:0];

endmodule

// ===== rtl/tcp_retransmit_timeout_estimator_core.sv =====
// Retransmit timer for one TCP connection.
// req carries one event per transfer: func 0 for bytes written, 1 for bytes
// acknowledged, 2 for a timer check, together with the current microsecond
// time, a byte count and the nothing_unacked flag. rsp returns exactly one
// result per event: the retransmit decision, the current timeout, the
// absolute deadline and whether a round-trip mark is open. cfg writes the
// initial timeout, the backoff step and the timeout cap in milliseconds;
// unknown indexes are ignored, and writes are always taken.
// One event is processed at a time on a shared arithmetic unit under
// a small sequencer. A write or check that does not schedule the timer goes
// from decode to the result; an ack first compares against the mark and may
// record a round-trip sample. Scheduling converts the initial timeout or adds
// the backoff step to the current one, then caps it and sets the deadline; a
// full ring instead starts from 1.5 times the ring mean, floored at 3000 us.
// req.ready rises in the cycle the result register loads, so the next event
// can be taken while that result is still shown. A result left waiting does not
// hold up the next event until that event's own result is ready to be loaded.
// Reset disarms the timer, closes the mark, empties the sample ring and
// loads the register defaults 1000 ms, 1000 ms and 10000 ms.
module tcp_retransmit_timeout_estimator_core import tcp_rto_pkg::*; #(
	parameter int SAMPLE_COUNT = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	tcp_rto_cfg_if.sink   cfg,
	tcp_rto_req_if.sink   req,
	tcp_rto_rsp_if.source rsp
);

	localparam int SUM_W = TIME_W + $clog2(SAMPLE_COUNT);
	localparam int ACC_W = (SUM_W > TIME_W + 2) ? SUM_W : TIME_W + 2;
	localparam int IDX_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_ACK_CMP  = 4'd2;
	localparam logic [3:0] S_SAMPLE   = 4'd3;
	localparam logic [3:0] S_SCHED    = 4'd4;
	localparam logic [3:0] S_BACKOFF  = 4'd5;
	localparam logic [3:0] S_SUM      = 4'd6;
	localparam logic [3:0] S_DIV      = 4'd7;
	localparam logic [3:0] S_HALF     = 4'd8;
	localparam logic [3:0] S_FLOOR    = 4'd9;
	localparam logic [3:0] S_CAP_MUL  = 4'd10;
	localparam logic [3:0] S_CAP      = 4'd11;
	localparam logic [3:0] S_DEADLINE = 4'd12;
	localparam logic [3:0] S_DONE     = 4'd13;

	logic [3:0] state_q;

	func_t  func_q;
	time_t  now_q;
	count_t count_q;
	logic   nun_q;

	ms_t init_ms_q;
	ms_t backoff_ms_q;
	ms_t max_ms_q;

	time_t            samples_q [SAMPLE_COUNT];
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] idx_q;
	logic             ring_full_q;
	logic             mark_open_q;
	time_t            written_q;
	time_t            acked_q;
	time_t            mark_bytes_q;
	time_t            mark_time_q;
	timeout_t         tv_q;
	time_t            deadline_q;
	logic [ACC_W-1:0] acc_q;
	timeout_t         cap_q;
	logic             fire_q;

	logic     out_valid_q;
	logic     out_retransmit_q;
	timeout_t out_timeout_q;
	time_t    out_deadline_q;
	logic     out_open_q;

	alu_op_t          alu_op;
	logic [ACC_W-1:0] alu_a;
	logic [ACC_W-1:0] alu_b;
	logic [ACC_W-1:0] alu_res;
	logic             alu_carry;
	time_t            span_w;
	time_t            res32;

	logic             div_start;
	logic             div_done;
	logic [SUM_W-1:0] div_quot;

	logic accept;
	logic load_out;

	// Wrap-aware elapsed time from a to b, given b - a and the borrow of that
	// subtraction (borrow set means a > b).
	function automatic time_t span(input logic borrow, input time_t d);
		time_t r;
		if (d == '0) begin
			r = '0;
		end else if (!borrow) begin
			r = d[TIME_W-1] ? '0 : d;
		end else begin
			r = (!d[TIME_W-1] || d[TIME_W-2:0] == '0) ? d : '0;
		end
		return r;
	endfunction

	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign res32  = alu_res[TIME_W-1:0];
	assign span_w = span(alu_carry, res32);

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_DECODE: begin
				case (func_q)
					FUNC_WRITE: begin
						alu_a = ACC_W'(written_q);
						alu_b = ACC_W'(count_q);
					end
					FUNC_ACK: begin
						alu_a = ACC_W'(acked_q);
						alu_b = ACC_W'(count_q);
					end
					FUNC_CHECK: begin
						alu_op = ALU_SUB;
						alu_a  = ACC_W'(deadline_q);
						alu_b  = ACC_W'(now_q);
					end
					default: begin
						alu_op = ALU_ADD;
					end
				endcase
			end
			S_ACK_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = ACC_W'(acked_q);
				alu_b  = ACC_W'(mark_bytes_q);
			end
			S_SAMPLE: begin
				alu_op = ALU_SUB;
				alu_a  = ACC_W'(now_q);
				alu_b  = ACC_W'(mark_time_q);
			end
			S_SCHED: begin
				alu_op = ALU_MS_TO_US;
				alu_a  = (tv_q != '0) ? ACC_W'(backoff_ms_q) : ACC_W'(init_ms_q);
			end
			S_BACKOFF: begin
				alu_a = acc_q;
				alu_b = ACC_W'(tv_q);
			end
			S_SUM: begin
				alu_a = acc_q;
				alu_b = ACC_W'(samples_q[idx_q]);
			end
			S_HALF: begin
				alu_a = acc_q;
				alu_b = acc_q >> 1;
			end
			S_FLOOR: begin
				alu_op = ALU_SUB;
				alu_a  = acc_q;
				alu_b  = ACC_W'(MIN_TIMEOUT_US);
			end
			S_CAP_MUL: begin
				alu_op = ALU_MS_TO_US;
				alu_a  = ACC_W'(max_ms_q);
			end
			S_CAP: begin
				alu_op = ALU_SUB;
				alu_a  = ACC_W'(cap_q);
				alu_b  = acc_q;
			end
			S_DEADLINE: begin
				alu_a = ACC_W'(now_q);
				alu_b = ACC_W'(tv_q);
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	tcp_rto_alu #(
		.WIDTH (ACC_W)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.carry (alu_carry)
	);

	// The last ring sample goes straight from the adder into the divider.
	assign div_start = (state_q == S_SUM) && (idx_q == LAST_IDX);

	tcp_rto_div #(
		.WIDTH   (SUM_W),
		.DIVISOR (SAMPLE_COUNT)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (alu_res[SUM_W-1:0]),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			init_ms_q    <= INITIAL_TIMEOUT_RST;
			backoff_ms_q <= BACKOFF_STEP_RST;
			max_ms_q     <= MAX_TIMEOUT_RST;
			slot_q       <= '0;
			idx_q        <= '0;
			ring_full_q  <= 1'b0;
			mark_open_q  <= 1'b0;
			written_q    <= '0;
			acked_q      <= '0;
			mark_bytes_q <= '0;
			mark_time_q  <= '0;
			tv_q         <= '0;
			deadline_q   <= '0;
			acc_q        <= '0;
			cap_q        <= '0;
			fire_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_INITIAL_TIMEOUT: init_ms_q    <= cfg.data;
					REG_BACKOFF_STEP:    backoff_ms_q <= cfg.data;
					REG_MAX_TIMEOUT:     max_ms_q     <= cfg.data;
					default:             init_ms_q    <= init_ms_q;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fire_q  <= 1'b0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (func_q)
						FUNC_WRITE: begin
							if (count_q != '0) begin
								written_q <= res32;
							end
							if (count_q != '0 && !mark_open_q) begin
								mark_open_q  <= 1'b1;
								mark_bytes_q <= res32;
								mark_time_q  <= now_q;
								tv_q         <= '0;
								deadline_q   <= '0;
								state_q      <= S_SCHED;
							end else begin
								state_q <= S_DONE;
							end
						end
						FUNC_ACK: begin
							acked_q <= res32;
							state_q <= S_ACK_CMP;
						end
						FUNC_CHECK: begin
							if (deadline_q != '0 && span_w == '0) begin
								if (!nun_q) begin
									fire_q  <= 1'b1;
									state_q <= S_SCHED;
								end else begin
									deadline_q <= '0;
									tv_q       <= '0;
									state_q    <= S_DONE;
								end
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_ACK_CMP: begin
					// The mark is met when acked minus marked is not negative.
					if (mark_open_q && !res32[TIME_W-1]) begin
						state_q <= S_SAMPLE;
					end else begin
						if (nun_q) begin
							deadline_q <= '0;
							tv_q       <= '0;
						end
						state_q <= S_DONE;
					end
				end
				S_SAMPLE: begin
					if (slot_q == LAST_IDX) begin
						slot_q      <= '0;
						ring_full_q <= 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
					mark_open_q  <= 1'b0;
					mark_bytes_q <= '0;
					mark_time_q  <= '0;
					if (nun_q) begin
						deadline_q <= '0;
						tv_q       <= '0;
					end
					state_q <= S_DONE;
				end
				S_SCHED: begin
					if (tv_q != '0) begin
						acc_q   <= alu_res;
						state_q <= S_BACKOFF;
					end else if (ring_full_q) begin
						acc_q   <= '0;
						idx_q   <= '0;
						state_q <= S_SUM;
					end else begin
						acc_q   <= alu_res;
						state_q <= S_CAP_MUL;
					end
				end
				S_BACKOFF: begin
					acc_q   <= alu_res;
					state_q <= S_CAP_MUL;
				end
				S_SUM: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_DIV;
					end else begin
						acc_q <= alu_res;
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						acc_q   <= ACC_W'(div_quot);
						state_q <= S_HALF;
					end
				end
				S_HALF: begin
					acc_q   <= alu_res;
					state_q <= S_FLOOR;
				end
				S_FLOOR: begin
					if (alu_carry) begin
						acc_q <= ACC_W'(MIN_TIMEOUT_US);
					end
					state_q <= S_CAP_MUL;
				end
				S_CAP_MUL: begin
					cap_q   <= alu_res[TIMEOUT_W-1:0];
					state_q <= S_CAP;
				end
				S_CAP: begin
					// A borrow means the candidate exceeds the cap.
					tv_q    <= alu_carry ? cap_q : acc_q[TIMEOUT_W-1:0];
					state_q <= S_DEADLINE;
				end
				S_DEADLINE: begin
					deadline_q <= (res32 == '0) ? TIME_W'(1) : res32;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Ring samples are read only once every slot has been written, so they
	// need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			now_q   <= req.now_us;
			count_q <= req.byte_count;
			nun_q   <= req.nothing_unacked;
		end
		if (state_q == S_SAMPLE) begin
			samples_q[slot_q] <= span_w;
		end
		if (load_out) begin
			out_retransmit_q <= fire_q;
			out_timeout_q    <= tv_q;
			out_deadline_q   <= deadline_q;
			out_open_q       <= mark_open_q;
		end
	end

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid       = out_valid_q;
	assign rsp.retransmit  = out_retransmit_q;
	assign rsp.timeout_us  = out_timeout_q;
	assign rsp.deadline_us = out_deadline_q;
	assign rsp.timing_open = out_open_q;

endmodule

// ===== rtl/tcp_rto_chk.sv =====
`include "tcp_retransmit_timeout_estimator_core_macros.svh"

module tcp_rto_chk import tcp_rto_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input logic     rsp_retransmit,
	input timeout_t rsp_timeout_us,
	input time_t    rsp_deadline_us
);

	// Each event occupies the sequencer, so no event is taken right after another.
	`TCP_RTO_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "event accepted on consecutive cycles")

	// A retransmit always reschedules, and a scheduled deadline is never zero.
	`TCP_RTO_ASSERT_IMP(a_fire_armed, clk, arst_n, rsp_valid && rsp_retransmit, rsp_deadline_us != '0, "retransmit with disarmed timer")

	// Timeout and deadline are cleared together, so a live timeout implies an armed timer.
	`TCP_RTO_ASSERT_IMP(a_timeout_armed, clk, arst_n, rsp_valid && rsp_timeout_us != '0, rsp_deadline_us != '0, "timeout without deadline")

	`TCP_RTO_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_deadline_us), "stalled result changed")

endmodule

bind tcp_retransmit_timeout_estimator_core tcp_rto_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_retransmit  (rsp.retransmit),
	.rsp_timeout_us  (rsp.timeout_us),
	.rsp_deadline_us (rsp.deadline_us)
);
